FILE: src/rgba_half_downsampler_defines.svh
// ----------------------------------------------------------------------------
// rgba_half_downsampler_defines.svh - assertion macros
// Concurrent assertion wrappers sampled on clk and disabled during reset.
// Define ASSERT_OFF to compile the assertions out.
// ----------------------------------------------------------------------------
`ifndef RGBA_HALF_DOWNSAMPLER_DEFINES_SVH
`define RGBA_HALF_DOWNSAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Assert a property on every clock edge outside reset
`define RHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition never holds outside reset
`define RHD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RHD_ASSERT(label, prop, msg)
`define RHD_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: src/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg - shared definitions for the RGBA half downsampler
// Pixel payload types, configuration register codes and size constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rhd_pkg;

    // Sizes
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 1;
    localparam int ROW_W         = 12;
    localparam int CH_W          = 8;
    localparam int SUM_W         = 9;
    localparam int NUM_CH        = 4;
    localparam int LINE_W        = SUM_W * NUM_CH;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } cfg_reg_t;

    // Source pixel
    typedef struct packed {
        logic [CH_W-1:0] in_alpha;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_red;
    } in_pix_t;

    // Averaged output pixel
    typedef struct packed {
        logic            frame_end;
        logic            row_end;
        logic [CH_W-1:0] out_alpha;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
    } out_pix_t;

    // Pair-sum stage contents
    typedef struct packed {
        logic              use_line;
        logic              row_end;
        logic              frame_end;
        logic [LINE_W-1:0] sums;
    } pair_stage_t;

endpackage

`default_nettype wire

FILE: src/rhd_stream_if.sv
// ----------------------------------------------------------------------------
// rhd_stream_if - valid/ready stream channel
// Carries one payload per transaction; accepted when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhd_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

`default_nettype wire

FILE: src/rgba_half_downsampler.sv
// ----------------------------------------------------------------------------
// rgba_half_downsampler - 2x2 box-filter halving of an RGBA pixel stream
// Averages each 2x2 block of a raster-order source image into one pixel.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock on src_pix and delivers half-size
// pixels on half_pix, each channel (sum of four values + 2) / 4. A result
// for the pixel that completes its block passes the pair-sum stage, with the
// registered read of the line store, and then the output register. A full
// rate of one pixel per clock is kept as long as half_pix is taken. Odd widths
// reuse the last column horizontally, odd heights pair the last row with
// itself. Writing src_width or src_height restarts the frame at row 0; write
// them only between frames. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgba_half_downsampler_defines.svh"

module rgba_half_downsampler #(
    parameter int MAX_WIDTH = rhd_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration write port
    input  wire logic                         cfg_write,
    input  wire logic [rhd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rhd_pkg::CFG_W-1:0]    cfg_data,
    // Pixel streams
    rhd_stream_if.sink                        src_pix,
    rhd_stream_if.source                      half_pix
);

    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (COL_W > rhd_pkg::CFG_W) ? COL_W : rhd_pkg::CFG_W;
    localparam int SW    = rhd_pkg::SUM_W;
    localparam int CW    = rhd_pkg::CH_W;
    localparam int NCH   = rhd_pkg::NUM_CH;
    localparam int LW    = rhd_pkg::LINE_W;
    localparam int RW    = rhd_pkg::ROW_W;
    localparam int HW    = rhd_pkg::CFG_W;

    // Configuration and position state
    logic [HW-1:0]    src_width_reg;
    logic [HW-1:0]    src_height_reg;
    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [RW-1:0]    row_count_reg;
    logic [RW-1:0]    row_count_next;
    logic [4*CW-1:0]  held_left_reg;

    // Effective geometry
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] eff_w;
    logic [CMP_W-1:0] w_m1;
    logic [HW-1:0]    eff_h;
    logic [HW-1:0]    h_m1;

    // Current position decode
    logic [COL_W-1:0] col;
    logic [RW-1:0]    row;
    logic             col_last;
    logic             row_last;
    logic             have_pair;
    logic             row_end_now;
    logic [AW-1:0]    line_addr;
    logic [4*CW-1:0]  cur_px;
    logic [4*CW-1:0]  left_px;
    logic [LW-1:0]    pair_sums;

    // Handshake and pipeline control
    logic             accept;
    logic             line_we;
    logic             produce;
    logic             out_free;
    logic             s1_free;
    logic             s1_valid_reg;
    rhd_pkg::pair_stage_t s1_reg;
    logic [LW-1:0]    line_rd_reg;
    logic             out_valid_reg;
    rhd_pkg::out_pix_t out_pix_reg;
    rhd_pkg::out_pix_t out_pix_next;
    logic [LW-1:0]    partner_sums;

    logic [LW-1:0]    line_mem [DEPTH];

    // Clamp configured size to the supported range
    always_comb
    begin
        width_ext = CMP_W'(src_width_reg);
        if (width_ext == '0)
            eff_w = CMP_W'(1);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            eff_w = CMP_W'(MAX_WIDTH);
        else
            eff_w = width_ext;
        w_m1 = eff_w - CMP_W'(1);

        if (src_height_reg == '0)
            eff_h = HW'(1);
        else if (src_height_reg > HW'(rhd_pkg::MAX_HEIGHT))
            eff_h = HW'(rhd_pkg::MAX_HEIGHT);
        else
            eff_h = src_height_reg;
        h_m1 = eff_h - HW'(1);
    end

    // Decode position, form horizontal pair sums, advance counters
    always_comb
    begin
        col = (CMP_W'(column_count_reg) > w_m1) ? '0 : column_count_reg;
        row = (HW'(row_count_reg) > h_m1) ? '0 : row_count_reg;
        col_last    = (CMP_W'(col) == w_m1);
        row_last    = (HW'(row) == h_m1);
        have_pair   = col[0] | col_last;
        row_end_now = (CMP_W'(col[COL_W-1:1]) >= (w_m1 >> 1));
        line_addr   = AW'(col[COL_W-1:1]);

        cur_px  = src_pix.payload;
        left_px = col[0] ? held_left_reg : cur_px;
        for (int c = 0; c < NCH; c++)
        begin
            pair_sums[SW*c +: SW] = SW'(left_px[CW*c +: CW]) + SW'(cur_px[CW*c +: CW]);
        end

        accept  = src_pix.valid & src_pix.ready;
        line_we = accept & have_pair & ~row[0] & ~row_last;
        produce = accept & have_pair & ~line_we;

        if (col_last)
        begin
            column_count_next = '0;
            row_count_next    = row_last ? '0 : row + RW'(1);
        end
        else
        begin
            column_count_next = col + COL_W'(1);
            row_count_next    = row;
        end
    end

    // Stall control: output register parts the two sides
    assign out_free      = ~out_valid_reg | half_pix.ready;
    assign s1_free       = ~s1_valid_reg | out_free;
    assign src_pix.ready = s1_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= HW'(1);
            src_height_reg <= HW'(1);
        end
        else if (cfg_write)
        begin
            unique case (rhd_pkg::cfg_reg_t'(cfg_index))
                rhd_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                rhd_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Position counters: restart the frame on any register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (cfg_write)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // Hold the even-column pixel until its right neighbor arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_left_reg <= '0;
        else if (accept && !have_pair)
            held_left_reg <= cur_px;
    end

    // Line store: write on even rows other than the last, read for the odd-row partner
    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[line_addr] <= pair_sums;
        if (produce && row[0])
            line_rd_reg <= line_mem[line_addr];
    end

    // Pair-sum stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= produce;
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            s1_reg.use_line  <= row[0];
            s1_reg.row_end   <= row_end_now;
            s1_reg.frame_end <= row_end_now & row_last;
            s1_reg.sums      <= pair_sums;
        end
    end

    // Combine with the vertical partner and round
    always_comb
    begin
        partner_sums = s1_reg.use_line ? line_rd_reg : s1_reg.sums;
        out_pix_next.out_red   = '0;
        out_pix_next.out_green = '0;
        out_pix_next.out_blue  = '0;
        out_pix_next.out_alpha = '0;
        for (int c = 0; c < NCH; c++)
        begin
            logic [SW+1:0] total;
            total = (SW+2)'(s1_reg.sums[SW*c +: SW]) + (SW+2)'(partner_sums[SW*c +: SW])
                  + (SW+2)'(2);
            case (c)
                0:       out_pix_next.out_red   = total[CW+1:2];
                1:       out_pix_next.out_green = total[CW+1:2];
                2:       out_pix_next.out_blue  = total[CW+1:2];
                default: out_pix_next.out_alpha = total[CW+1:2];
            endcase
        end
        out_pix_next.row_end   = s1_reg.row_end;
        out_pix_next.frame_end = s1_reg.frame_end;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
            out_pix_reg <= out_pix_next;
    end

    assign half_pix.valid   = out_valid_reg;
    assign half_pix.payload = out_pix_reg;

    // Checks
    `RHD_ASSERT(a_frame_end_on_row_end,
        half_pix.valid |-> (!half_pix.payload.frame_end || half_pix.payload.row_end),
        "frame_end without row_end")
    `RHD_ASSERT_NEVER(a_col_in_range, CMP_W'(column_count_reg) > w_m1,
        "column counter beyond image width")
    `RHD_ASSERT_NEVER(a_row_in_range, HW'(row_count_reg) > h_m1,
        "row counter beyond image height")
    `RHD_ASSERT(a_stall_blocks_input, (s1_valid_reg && !out_free) |-> !src_pix.ready,
        "input accepted while pair stage is stalled")
    `RHD_ASSERT(a_odd_pair_produces, (accept && col[0] && row[0]) |=> s1_valid_reg,
        "odd-row pair did not produce a result")

endmodule

`default_nettype wire
